[design/ncs_pkg.sv]
`timescale 1ns / 1ps

package ncs_pkg;

    localparam int MAX_CENTERS = 256;
    localparam int COORD_BITS  = 16;

    localparam int FUNC_W   = 2;
    localparam int IN_W     = 16;
    localparam int INDEX_W  = 8;
    localparam int DIST_W   = 34;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } func_t;

    typedef struct packed {
        logic take;
        logic start_scan;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_done;
    } sts_t;

endpackage

[design/nearest_center_search_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  func, px, py, pz
// output    out        out_valid / out_stall found, nearest_index, nearest_dist_sq
//
// Clear and append complete without leaving the idle state. A query is paced by
// the single memory read port scanning one center per cycle through a
// four-stage distance pipe; an empty-table query skips the scan.
// Reset clears the center count and all control state; the center memory is
// not cleared. Inputs are taken while a result waits; a finished query holds
// until the output register frees.

module nearest_center_search_core
#(
    parameter int MAX_CENTERS = ncs_pkg::MAX_CENTERS,
    parameter int COORD_BITS  = ncs_pkg::COORD_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ncs_pkg::FUNC_W-1:0]      func,
    input  logic signed [ncs_pkg::IN_W-1:0] px,
    input  logic signed [ncs_pkg::IN_W-1:0] py,
    input  logic signed [ncs_pkg::IN_W-1:0] pz,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [ncs_pkg::INDEX_W-1:0]     nearest_index,
    output logic [ncs_pkg::DIST_W-1:0]      nearest_dist_sq
);

    ncs_pkg::cmd_t cmd;
    ncs_pkg::sts_t sts;

    ncs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ncs_datapath
    #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .px              (px),
        .py              (py),
        .pz              (pz),
        .found           (found),
        .nearest_index   (nearest_index),
        .nearest_dist_sq (nearest_dist_sq)
    );

endmodule

[design/ncs_ctrl.sv]
`timescale 1ns / 1ps

module ncs_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ncs_pkg::FUNC_W-1:0] func,
    output logic                     out_valid,
    input  logic                     out_stall,
    output ncs_pkg::cmd_t            cmd,
    input  ncs_pkg::sts_t            sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   is_query;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_query  = (func == ncs_pkg::FUNC_QUERY);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.take       = in_valid && (state_reg == ST_IDLE);
        cmd.start_scan = 1'b0;
        cmd.load_out   = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take && is_query)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = sts.count_zero ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/ncs_datapath.sv]
`timescale 1ns / 1ps

module ncs_datapath
#(
    parameter int MAX_CENTERS = ncs_pkg::MAX_CENTERS,
    parameter int COORD_BITS  = ncs_pkg::COORD_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ncs_pkg::cmd_t               cmd,
    output ncs_pkg::sts_t               sts,
    input  logic [ncs_pkg::FUNC_W-1:0]  func,
    input  logic signed [ncs_pkg::IN_W-1:0] px,
    input  logic signed [ncs_pkg::IN_W-1:0] py,
    input  logic signed [ncs_pkg::IN_W-1:0] pz,
    output logic                        found,
    output logic [ncs_pkg::INDEX_W-1:0] nearest_index,
    output logic [ncs_pkg::DIST_W-1:0]  nearest_dist_sq
);

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CENTERS + 1);
    localparam int ENT_W = 3 * CB;
    localparam int DF_W  = CB + 1;
    localparam int SQ_W  = 2 * CB + 1;
    localparam int SUM_W = SQ_W + 2;

    logic [ENT_W-1:0] mem [MAX_CENTERS];

    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic signed [CB-1:0] cz;

    logic [CNT_W-1:0]     count_reg;
    logic signed [CB-1:0] qx_reg;
    logic signed [CB-1:0] qy_reg;
    logic signed [CB-1:0] qz_reg;

    logic             issue_active_reg;
    logic [IDX_W-1:0] issue_idx_reg;
    logic             issue_last;

    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [ENT_W-1:0] rd_data_reg;

    logic              s2_valid_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic signed [DF_W-1:0] dx_reg;
    logic signed [DF_W-1:0] dy_reg;
    logic signed [DF_W-1:0] dz_reg;

    logic             s3_valid_reg;
    logic [IDX_W-1:0] s3_idx_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [SQ_W-1:0]  sqz_reg;

    logic             s4_valid_reg;
    logic [IDX_W-1:0] s4_idx_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             best_valid_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [SUM_W-1:0] best_dist_reg;

    logic signed [CB-1:0] mx;
    logic signed [CB-1:0] my;
    logic signed [CB-1:0] mz;
    logic signed [2*DF_W-1:0] prod_x;
    logic signed [2*DF_W-1:0] prod_y;
    logic signed [2*DF_W-1:0] prod_z;

    logic found_reg;
    logic [ncs_pkg::INDEX_W-1:0] index_reg;
    logic [ncs_pkg::DIST_W-1:0]  dist_reg;

    logic do_append;

    assign cx = CB'(px);
    assign cy = CB'(py);
    assign cz = CB'(pz);

    assign do_append = cmd.take && (func == ncs_pkg::FUNC_APPEND)
                       && (count_reg < CNT_W'(MAX_CENTERS));

    assign issue_last = ((CNT_W'(issue_idx_reg) + CNT_W'(1)) == count_reg);

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_done  = !issue_active_reg && !s1_valid_reg && !s2_valid_reg
                            && !s3_valid_reg && !s4_valid_reg;

    assign mx = signed'(rd_data_reg[3*CB-1:2*CB]);
    assign my = signed'(rd_data_reg[2*CB-1:CB]);
    assign mz = signed'(rd_data_reg[CB-1:0]);

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;

    assign found           = found_reg;
    assign nearest_index   = index_reg;
    assign nearest_dist_sq = dist_reg;

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            mem[count_reg[IDX_W-1:0]] <= {cx, cy, cz};
        end
        rd_data_reg <= mem[issue_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.take)
        begin
            unique case (func)
                ncs_pkg::FUNC_CLEAR:
                begin
                    count_reg <= '0;
                end
                ncs_pkg::FUNC_APPEND:
                begin
                    if (do_append)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_active_reg <= 1'b0;
            issue_idx_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            best_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_active_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;

            if (cmd.start_scan)
            begin
                issue_active_reg <= (count_reg != '0);
                issue_idx_reg    <= '0;
                best_valid_reg   <= 1'b0;
            end
            else
            begin
                if (issue_active_reg)
                begin
                    issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                    if (issue_last)
                    begin
                        issue_active_reg <= 1'b0;
                    end
                end
                if (s4_valid_reg)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_scan)
        begin
            qx_reg <= cx;
            qy_reg <= cy;
            qz_reg <= cz;
        end

        s1_idx_reg <= issue_idx_reg;

        s2_idx_reg <= s1_idx_reg;
        dx_reg     <= DF_W'(mx) - DF_W'(qx_reg);
        dy_reg     <= DF_W'(my) - DF_W'(qy_reg);
        dz_reg     <= DF_W'(mz) - DF_W'(qz_reg);

        s3_idx_reg <= s2_idx_reg;
        sqx_reg    <= prod_x[SQ_W-1:0];
        sqy_reg    <= prod_y[SQ_W-1:0];
        sqz_reg    <= prod_z[SQ_W-1:0];

        s4_idx_reg <= s3_idx_reg;
        sum_reg    <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

        if (s4_valid_reg && (!best_valid_reg || (sum_reg < best_dist_reg)))
        begin
            best_idx_reg  <= s4_idx_reg;
            best_dist_reg <= sum_reg;
        end

        if (cmd.load_out)
        begin
            found_reg <= best_valid_reg;
            index_reg <= best_valid_reg ? ncs_pkg::INDEX_W'(best_idx_reg) : '0;
            dist_reg  <= best_valid_reg ? ncs_pkg::DIST_W'(best_dist_reg) : '0;
        end
    end

endmodule

[design/ncs_checker.sv]
`timescale 1ns / 1ps

module ncs_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        found,
    input logic [ncs_pkg::INDEX_W-1:0] nearest_index,
    input logic [ncs_pkg::DIST_W-1:0]  nearest_dist_sq
);

    // results are loaded only while the input side is busy with a query
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a query in progress");

    a_empty_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (nearest_index == '0 && nearest_dist_sq == '0))
        else $error("empty-table result carries nonzero fields");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(found) && $stable(nearest_index) && $stable(nearest_dist_sq)))
        else $error("result changed while stalled");

endmodule

bind nearest_center_search_core ncs_checker u_ncs_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .found           (found),
    .nearest_index   (nearest_index),
    .nearest_dist_sq (nearest_dist_sq)
);
